### rtl/core/local_rms_window_5x5_top_assert.svh
// Assertion macros for the local RMS window block.
// Used by the port checker; needs a clk and an rst_n in scope.
`ifndef LOCAL_RMS_WINDOW_5X5_TOP_ASSERT_SVH
`define LOCAL_RMS_WINDOW_5X5_TOP_ASSERT_SVH

// same-cycle implication
`define LRW_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

// next-cycle implication
`define LRW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

### rtl/core/lrw_pkg.sv
// Shared constants, types and helper functions of the local RMS window block.
// No dependencies.
package lrw_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int WIDTH_LIMIT = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int MEM_AW      = $clog2(MAX_WIDTH);
    localparam int LINES       = 4;
    localparam int WINDOW_SIZE = 5;
    localparam int COL_W       = 10;
    localparam int ROW_W       = 11;
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int SAMPLE_W    = 17;
    localparam int SQ_W        = 34;
    localparam int COLSUM_W    = 35;
    localparam int WSUM_W      = 37;
    localparam int SCALED_W    = WSUM_W + 8;
    localparam int SQRT_IN_W   = SCALED_W + 1;
    localparam int SQRT_STEPS  = SQRT_IN_W / 2;
    localparam int ROOT_W      = SQRT_STEPS;
    localparam int SREM_W      = ROOT_W + 2;
    localparam int STEP_W      = 6;
    localparam int RMS_W       = 20;
    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = 2;

    // floor(x / 5) = (x * RECIP_5) >> RECIP_SHIFT for any x below 2**23
    localparam int RECIP_W     = 24;
    localparam int RECIP_SHIFT = 26;
    localparam logic [RECIP_W-1:0] RECIP_5 = 24'hCCCCCD;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    typedef struct packed {
        logic [COLSUM_W-1:0] colsum;
        logic [9:0]          out_row;
        logic [9:0]          out_col;
        logic                col_first;
        logic                emit;
        logic                row_end;
        logic                frame_end;
    } col_item_t;

    function automatic logic [CFG_W-1:0] eff_width(input logic [CFG_W-1:0] w);
        logic [CFG_W-1:0] r;
        r = w;
        if (r > CFG_W'(WIDTH_LIMIT)) r = CFG_W'(WIDTH_LIMIT);
        if (r < CFG_W'(3)) r = CFG_W'(3);
        return r;
    endfunction

    function automatic logic [CFG_W-1:0] eff_height(input logic [CFG_W-1:0] h);
        logic [CFG_W-1:0] r;
        r = h;
        if (r > CFG_W'(1024)) r = CFG_W'(1024);
        if (r < CFG_W'(1)) r = CFG_W'(1);
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] sq_mag(input logic [SAMPLE_W-1:0] p);
        return p[SAMPLE_W-1] ? (SAMPLE_W'(0) - p) : p;
    endfunction

endpackage

### rtl/core/lrw_fifo.sv
// Short queue of column items between the front and back parts.
// Depends on lrw_pkg.
module lrw_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lrw_pkg::col_item_t din,
    output logic              full,
    input  logic              pop,
    output lrw_pkg::col_item_t dout,
    output logic              empty
);

    lrw_pkg::col_item_t           entry_reg [lrw_pkg::Q_DEPTH];
    logic [lrw_pkg::Q_AW-1:0]     wr_ptr_reg;
    logic [lrw_pkg::Q_AW-1:0]     rd_ptr_reg;
    logic [lrw_pkg::Q_AW:0]       count_reg;
    logic [lrw_pkg::Q_AW:0]       count_next;

    assign full  = (count_reg == (lrw_pkg::Q_AW + 1)'(lrw_pkg::Q_DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + 1'b1;
        if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) entry_reg[wr_ptr_reg] <= din;
    end

endmodule

### rtl/core/lrw_front.sv
// Front part: accepts samples, keeps the circular line store and positions,
// and builds one column sum of squares per item. Depends on lrw_pkg.
module lrw_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          restart,
    input  logic [lrw_pkg::CFG_W-1:0]     cfg_width,
    input  logic [lrw_pkg::CFG_W-1:0]     cfg_height,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_mode,
    input  logic [lrw_pkg::SAMPLE_W-1:0]  in_value,
    output logic                          q_push,
    input  logic                          q_full,
    output lrw_pkg::col_item_t            q_data
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MAC  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;
    localparam int WORD_W = lrw_pkg::LINES * lrw_pkg::SAMPLE_W;

    logic [1:0]                      state_reg;
    logic [lrw_pkg::ROW_W-1:0]       row_reg;
    logic [lrw_pkg::COL_W-1:0]       col_reg;
    logic [lrw_pkg::ROW_W-1:0]       cur_row_reg;
    logic [lrw_pkg::COL_W-1:0]       cur_col_reg;
    logic [lrw_pkg::SAMPLE_W-1:0]    sample_reg;
    logic [WORD_W-1:0]               lines_reg;
    logic [2:0]                      k_reg;
    logic [lrw_pkg::COLSUM_W-1:0]    acc_reg;
    logic [WORD_W-1:0]               line_mem [lrw_pkg::MAX_WIDTH];

    logic [lrw_pkg::CFG_W-1:0]       w;
    logic [lrw_pkg::CFG_W-1:0]       h;
    logic [lrw_pkg::CFG_W:0]         h_plus2;
    logic [lrw_pkg::ROW_W-1:0]       row_eff;
    logic [lrw_pkg::COL_W-1:0]       col_eff;
    logic [lrw_pkg::SAMPLE_W-1:0]    sample_in;
    logic                            accept;
    logic [1:0]                      slot;
    logic [lrw_pkg::SAMPLE_W-1:0]    operand;
    logic                            op_valid;
    logic [lrw_pkg::SAMPLE_W-1:0]    mag;
    logic [lrw_pkg::SQ_W-1:0]        prod;
    logic [WORD_W-1:0]               wr_word;
    logic [lrw_pkg::COL_W:0]         col_inc;
    logic [lrw_pkg::CFG_W:0]         row_inc;

    assign w        = lrw_pkg::eff_width(cfg_width);
    assign h        = lrw_pkg::eff_height(cfg_height);
    assign h_plus2  = {1'b0, h} + (lrw_pkg::CFG_W + 1)'(2);
    assign in_ready = (state_reg == F_IDLE);
    assign accept   = in_valid && in_ready;
    assign q_push   = (state_reg == F_PUSH) && !q_full;

    always_comb
    begin
        row_eff = ({1'b0, row_reg} >= h_plus2) ? '0 : row_reg;
        col_eff = ({1'b0, col_reg} >= w) ? '0 : col_reg;
        sample_in = (!in_mode && (row_eff < h)) ? in_value : '0;
    end

    // select one tap per step: k 0 is the new sample, k 1..4 the rows above
    always_comb
    begin
        slot = cur_row_reg[1:0] - k_reg[1:0];
        if (k_reg == 3'd0)
        begin
            operand  = sample_reg;
            op_valid = 1'b1;
        end
        else
        begin
            operand  = lines_reg[slot*lrw_pkg::SAMPLE_W +: lrw_pkg::SAMPLE_W];
            op_valid = (cur_row_reg >= lrw_pkg::ROW_W'(k_reg));
        end
        mag  = lrw_pkg::sq_mag(operand);
        prod = lrw_pkg::SQ_W'(mag) * lrw_pkg::SQ_W'(mag);
    end

    always_comb
    begin
        wr_word = lines_reg;
        wr_word[cur_row_reg[1:0]*lrw_pkg::SAMPLE_W +: lrw_pkg::SAMPLE_W] = sample_reg;
        col_inc = {1'b0, cur_col_reg} + 1'b1;
        row_inc = {1'b0, cur_row_reg} + 1'b1;
    end

    always_comb
    begin
        q_data.colsum    = acc_reg;
        q_data.out_row   = 10'(cur_row_reg - lrw_pkg::ROW_W'(2));
        q_data.out_col   = cur_col_reg - lrw_pkg::COL_W'(2);
        q_data.col_first = (cur_col_reg == '0);
        q_data.emit      = (cur_row_reg >= lrw_pkg::ROW_W'(2))
                           && (cur_col_reg >= lrw_pkg::COL_W'(2));
        q_data.row_end   = ({1'b0, cur_col_reg} == (w - 1'b1));
        q_data.frame_end = ({1'b0, cur_row_reg} == (h_plus2 - 1'b1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            k_reg     <= '0;
        end
        else if (restart)
        begin
            state_reg <= F_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        k_reg     <= '0;
                        state_reg <= F_MAC;
                    end
                end
                F_MAC:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == 3'(lrw_pkg::WINDOW_SIZE - 1)) state_reg <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (!q_full)
                    begin
                        state_reg <= F_IDLE;
                        if (col_inc >= w)
                        begin
                            col_reg <= '0;
                            row_reg <= (row_inc >= h_plus2) ? '0 : row_inc[lrw_pkg::ROW_W-1:0];
                        end
                        else
                        begin
                            col_reg <= col_inc[lrw_pkg::COL_W-1:0];
                            row_reg <= cur_row_reg;
                        end
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    // payload and line store
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_row_reg <= row_eff;
            cur_col_reg <= col_eff;
            sample_reg  <= sample_in;
            lines_reg   <= line_mem[col_eff[lrw_pkg::MEM_AW-1:0]];
            acc_reg     <= '0;
        end
        else if (state_reg == F_MAC)
        begin
            if (op_valid) acc_reg <= acc_reg + lrw_pkg::COLSUM_W'(prod);
        end
        if (q_push) line_mem[cur_col_reg[lrw_pkg::MEM_AW-1:0]] <= wr_word;
    end

endmodule

### rtl/core/lrw_back.sv
// Back part: slides the 5-column window and turns each window sum into
// floor(sqrt(sum*256)/5) with a serial square root and a reciprocal multiply.
// Depends on lrw_pkg.
module lrw_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_empty,
    output logic                       q_pop,
    input  lrw_pkg::col_item_t         q_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [lrw_pkg::RMS_W-1:0]  out_rms,
    output logic [9:0]                 out_row,
    output logic [9:0]                 out_col,
    output logic                       out_last_run,
    output logic                       out_last_frame
);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_SQRT = 2'd1;
    localparam logic [1:0] B_OUT  = 2'd2;
    localparam int PROD_W = lrw_pkg::ROOT_W + lrw_pkg::RECIP_W;

    logic [1:0]                        state_reg;
    logic [lrw_pkg::COLSUM_W-1:0]      cs_reg [lrw_pkg::WINDOW_SIZE];
    logic [lrw_pkg::WSUM_W-1:0]        ws_reg;
    lrw_pkg::col_item_t                item_reg;
    logic [1:0]                        k_reg;
    logic [lrw_pkg::STEP_W-1:0]        step_reg;
    logic [lrw_pkg::SQRT_IN_W-1:0]     sx_reg;
    logic [lrw_pkg::SREM_W-1:0]        srem_reg;
    logic [lrw_pkg::ROOT_W-1:0]        root_reg;

    logic                              do_shift;
    logic                              shift_clear;
    logic [lrw_pkg::COLSUM_W-1:0]      shift_val;
    logic [lrw_pkg::WSUM_W-1:0]        ws_shifted;
    logic                              more;
    logic [lrw_pkg::SREM_W+1:0]        st;
    logic [lrw_pkg::SREM_W+1:0]        trial;
    logic                              sge;
    logic [lrw_pkg::ROOT_W-1:0]        root_next;
    logic [PROD_W-1:0]                 scaled;
    logic [lrw_pkg::RMS_W:0]           root_div5;

    assign q_pop     = (state_reg == B_IDLE) && !q_empty;
    assign more      = item_reg.row_end && (k_reg != 2'd2);
    assign out_valid = (state_reg == B_OUT);
    assign out_row   = item_reg.out_row;
    assign out_col   = item_reg.out_col + 10'(k_reg);
    assign out_last_run   = !item_reg.row_end || (k_reg == 2'd2);
    assign out_last_frame = item_reg.row_end && item_reg.frame_end && (k_reg == 2'd2);

    // divide the root by five and saturate
    assign scaled    = PROD_W'(root_reg) * PROD_W'(lrw_pkg::RECIP_5);
    assign root_div5 = scaled[lrw_pkg::RECIP_SHIFT +: lrw_pkg::RMS_W + 1];
    assign out_rms   = root_div5[lrw_pkg::RMS_W] ? {lrw_pkg::RMS_W{1'b1}}
                                                 : root_div5[lrw_pkg::RMS_W-1:0];

    // window shift: new column from the queue, or a zero column at row end
    always_comb
    begin
        do_shift    = q_pop || (out_valid && out_ready && more);
        shift_clear = q_pop && q_data.col_first;
        shift_val   = q_pop ? q_data.colsum : '0;
        if (shift_clear) ws_shifted = lrw_pkg::WSUM_W'(shift_val);
        else ws_shifted = ws_reg - lrw_pkg::WSUM_W'(cs_reg[0])
                          + lrw_pkg::WSUM_W'(shift_val);
    end

    always_comb
    begin
        st        = {srem_reg, sx_reg[lrw_pkg::SQRT_IN_W-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        sge       = (st >= trial);
        root_next = {root_reg[lrw_pkg::ROOT_W-2:0], sge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            ws_reg    <= '0;
            k_reg     <= '0;
            step_reg  <= '0;
            for (int i = 0; i < lrw_pkg::WINDOW_SIZE; i++) cs_reg[i] <= '0;
        end
        else
        begin
            if (do_shift)
            begin
                for (int i = 0; i < lrw_pkg::WINDOW_SIZE - 1; i++)
                    cs_reg[i] <= shift_clear ? '0 : cs_reg[i+1];
                cs_reg[lrw_pkg::WINDOW_SIZE-1] <= shift_val;
                ws_reg <= ws_shifted;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (q_pop && q_data.emit)
                    begin
                        k_reg     <= '0;
                        step_reg  <= '0;
                        state_reg <= B_SQRT;
                    end
                end
                B_SQRT:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == lrw_pkg::STEP_W'(lrw_pkg::SQRT_STEPS - 1))
                        state_reg <= B_OUT;
                end
                B_OUT:
                begin
                    if (out_ready)
                    begin
                        if (more)
                        begin
                            k_reg     <= k_reg + 1'b1;
                            step_reg  <= '0;
                            state_reg <= B_SQRT;
                        end
                        else
                        begin
                            state_reg <= B_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    // datapath of the square root
    always_ff @(posedge clk)
    begin
        if (q_pop) item_reg <= q_data;
        if (do_shift)
        begin
            sx_reg   <= {1'b0, ws_shifted, 8'h00};
            srem_reg <= '0;
            root_reg <= '0;
        end
        else if (state_reg == B_SQRT)
        begin
            srem_reg <= sge ? lrw_pkg::SREM_W'(st - trial) : lrw_pkg::SREM_W'(st);
            root_reg <= root_next;
            sx_reg   <= {sx_reg[lrw_pkg::SQRT_IN_W-3:0], 2'b00};
        end
    end

endmodule

### rtl/core/local_rms_window_5x5_top.sv
// Top level of the local 5x5 RMS window block.
// Depends on lrw_pkg, lrw_front, lrw_fifo and lrw_back.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------------
//  s_*     | in        | s_tvalid/s_tready  | tdata detail_value, tuser mode
//  m_*     | out       | m_tvalid/m_tready  | tdata rms,row,col; tlast run, tuser frame
//  cfg_*   | in        | cfg_valid/cfg_ready| cfg_index register, cfg_data value
//
// Front finishes each item before accepting the next: accept with line
// store read, five multiply-accumulate steps on one shared multiplier,
// then queue push and line store write. Back pops one column per cycle
// when idle, then spends 23 root steps and an output state on each result,
// up to three results per item.
// Reset clears positions, window sums, queue and config (width and height 1024).
// A full queue stalls the front; a stalled output holds the back.
module local_rms_window_5x5_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [16:0] detail_value, [23:17] zero
    input  logic        s_tuser,   // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [19:0] rms_value, [29:20] out_row, [39:30] out_column
    output logic        m_tlast,   // last_of_run
    output logic        m_tuser,   // [0] last_of_frame
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [lrw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lrw_pkg::CFG_W-1:0]     cfg_data
);

    logic [lrw_pkg::CFG_W-1:0] width_reg;
    logic [lrw_pkg::CFG_W-1:0] height_reg;
    logic                      restart;
    logic                      q_push;
    logic                      q_full;
    logic                      q_pop;
    logic                      q_empty;
    lrw_pkg::col_item_t        q_in;
    lrw_pkg::col_item_t        q_out;
    logic [lrw_pkg::RMS_W-1:0] rms;
    logic [9:0]                row;
    logic [9:0]                col;

    // configuration is always taken; a known register also restarts the frame
    assign cfg_ready = 1'b1;
    assign restart   = cfg_valid && ((cfg_index == lrw_pkg::REG_IMAGE_WIDTH)
                                  || (cfg_index == lrw_pkg::REG_IMAGE_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= lrw_pkg::CFG_W'(1024);
            height_reg <= lrw_pkg::CFG_W'(1024);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == lrw_pkg::REG_IMAGE_WIDTH)  width_reg  <= cfg_data;
            if (cfg_index == lrw_pkg::REG_IMAGE_HEIGHT) height_reg <= cfg_data;
        end
    end

    lrw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (restart),
        .cfg_width  (width_reg),
        .cfg_height (height_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_mode    (s_tuser),
        .in_value   (s_tdata[lrw_pkg::SAMPLE_W-1:0]),
        .q_push     (q_push),
        .q_full     (q_full),
        .q_data     (q_in)
    );

    lrw_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_in),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_out),
        .empty (q_empty)
    );

    lrw_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .q_data         (q_out),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_rms        (rms),
        .out_row        (row),
        .out_col        (col),
        .out_last_run   (m_tlast),
        .out_last_frame (m_tuser)
    );

    // pack the result fields, lowest first
    assign m_tdata = {col, row, rms};

endmodule

### rtl/core/lrw_checker.sv
// Port checker of the local RMS window block, bound to the top level.
// Depends on local_rms_window_5x5_top_assert.svh.
`include "local_rms_window_5x5_top_assert.svh"

module lrw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    // a stalled result holds
    `LRW_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // the frame's last result always closes its run
    `LRW_ASSERT_IMPL(a_frame_ends_run, m_tvalid && m_tuser, m_tlast)

    // the bottom-right pixel sits at least in column 2
    `LRW_ASSERT_IMPL(a_frame_col, m_tvalid && m_tuser, m_tdata[39:30] >= 10'd2)

endmodule

bind local_rms_window_5x5_top lrw_checker u_lrw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

### test/local_rms_window_5x5_top_test.sv
// Testbench of local_rms_window_5x5_top: streams small frames of signed detail samples and
// checks every windowed RMS result against a cycle-free predictor of the 5x5 window.
// Depends on lrw_pkg and the block's RTL.
`timescale 1ns / 100ps

module local_rms_window_5x5_top_test;

    localparam int CLK_PERIOD   = 10;
    localparam int CYCLE_LIMIT  = 1000000;
    // Each result costs the back end a full square root and an item yields up to three of
    // them; the settle wait leaves room for the front end to finish items that yield nothing.
    localparam int SETTLE_CYCLES = 400;
    localparam int PHASE_ITEMS   = 75;
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_FLUSH  = 1'b1;

    typedef struct {
        logic [19:0] rms;
        logic [9:0]  row;
        logic [9:0]  col;
        logic        run_end;
        logic        frame_end;
    } rms_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [lrw_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [lrw_pkg::CFG_W-1:0]     cfg_data;

    // Predictor state: a copy of the window pipeline in plain arithmetic.
    logic [16:0] line_mem [lrw_pkg::LINES][lrw_pkg::MAX_WIDTH];
    logic [34:0] col_sums [lrw_pkg::WINDOW_SIZE];
    logic [36:0] win_sum;
    int          row_pos;
    int          col_pos;
    logic [10:0] width_reg;
    logic [10:0] height_reg;

    rms_result_t pending_rms [$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          sender_idle_pct;
    int          rx_stall_pct;
    int          hold_token;
    int          hold_seen;
    int          hold_left;

    local_rms_window_5x5_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [33:0] square_of(input logic [16:0] p);
        logic [17:0] mag;
        mag = p[16] ? (18'h20000 - {1'b0, p}) : {1'b0, p};
        return mag * mag;
    endfunction

    function automatic logic [63:0] floor_root(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic int active_width();
        int w;
        w = width_reg;
        if (w > lrw_pkg::WIDTH_LIMIT) w = lrw_pkg::WIDTH_LIMIT;
        if (w < 3) w = 3;
        return w;
    endfunction

    function automatic int active_height();
        int h;
        h = height_reg;
        if (h > 1024) h = 1024;
        if (h < 1) h = 1;
        return h;
    endfunction

    task automatic restart_frame();
        for (int k = 0; k < lrw_pkg::WINDOW_SIZE; k++)
            col_sums[k] = '0;
        win_sum = '0;
        row_pos = 0;
        col_pos = 0;
    endtask

    task automatic slide_window(input logic [34:0] colsum);
        for (int k = 0; k < lrw_pkg::WINDOW_SIZE - 1; k++)
            col_sums[k] = col_sums[k + 1];
        col_sums[lrw_pkg::WINDOW_SIZE - 1] = colsum;
        win_sum = '0;
        for (int k = 0; k < lrw_pkg::WINDOW_SIZE; k++)
            win_sum = win_sum + col_sums[k];
    endtask

    function automatic rms_result_t window_rms(input int row, input int col);
        rms_result_t r;
        logic [63:0] root;
        root = floor_root((64'(win_sum) * 256) / 25);
        r.rms       = (root > 64'hFFFFF) ? 20'hFFFFF : root[19:0];
        r.row       = row[9:0];
        r.col       = col[9:0];
        r.run_end   = 1'b0;
        r.frame_end = 1'b0;
        return r;
    endfunction

    // Advance the predictor by one accepted item and queue what it yields.
    task automatic predict_window(input logic mode, input logic [16:0] value);
        int          w;
        int          h;
        int          row;
        int          col;
        logic [16:0] sample;
        logic [34:0] colsum;
        rms_result_t outs [3];
        int          n;
        w = active_width();
        h = active_height();
        row = row_pos;
        col = col_pos;
        n = 0;
        if (row >= h + 2) row = 0;
        if (col >= w) col = 0;
        sample = (mode == MODE_SAMPLE && row < h) ? value : 17'd0;
        colsum = square_of(sample);
        for (int k = 1; k < lrw_pkg::WINDOW_SIZE; k++)
            if (row >= k)
                colsum = colsum + square_of(line_mem[(row - k) & 3][col]);
        line_mem[row & 3][col] = sample;
        if (col == 0)
        begin
            for (int k = 0; k < lrw_pkg::WINDOW_SIZE; k++)
                col_sums[k] = '0;
            win_sum = '0;
        end
        slide_window(colsum);
        if (row >= 2 && col >= 2)
        begin
            outs[n] = window_rms(row - 2, col - 2);
            n = n + 1;
            if (col == w - 1)
            begin
                slide_window('0);
                outs[n] = window_rms(row - 2, col - 1);
                n = n + 1;
                slide_window('0);
                outs[n] = window_rms(row - 2, col);
                n = n + 1;
                if (row == h + 1)
                    outs[n - 1].frame_end = 1'b1;
            end
            outs[n - 1].run_end = 1'b1;
            for (int k = 0; k < n; k++)
                pending_rms.push_back(outs[k]);
        end
        col++;
        if (col >= w)
        begin
            col = 0;
            row++;
            if (row >= h + 2) row = 0;
        end
        row_pos = row;
        col_pos = col;
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic send_item(input logic mode, input logic [16:0] value);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, value};
        s_tuser  <= mode;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_window(mode, value);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
    endtask

    // Drop valid and let every expected result and any in-flight item drain.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_rms.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [lrw_pkg::CFG_IDX_W-1:0] index,
                             input logic [10:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (index == lrw_pkg::REG_IMAGE_WIDTH)
            width_reg = value;
        else
            height_reg = value;
        restart_frame();
    endtask

    task automatic set_frame(input logic [10:0] w, input logic [10:0] h);
        wait_idle();
        write_reg(lrw_pkg::REG_IMAGE_WIDTH, w);
        write_reg(lrw_pkg::REG_IMAGE_HEIGHT, h);
    endtask

    function automatic logic [16:0] pick_sample();
        case ($urandom_range(9))
            0: return 17'h10000;            // most negative, largest square
            1: return 17'h0FFFF;
            2: return 17'h10001;
            default: return 17'($urandom_range(17'h1FFFF));
        endcase
    endfunction

    // Extremes of the sample, flush inside the frame, clamped registers.
    task automatic test_directed_edges();
        logic [16:0] row0 [3];
        row0 = '{17'h0FFFF, 17'h10001, 17'h10000};
        set_frame(11'd0, 11'd1);            // width clamps up to 3
        foreach (row0[i])
            send_item(MODE_SAMPLE, row0[i]);
        // Flush rows read as zero whatever the mode and value.
        send_item(MODE_SAMPLE, 17'h1FFFF);
        send_item(MODE_FLUSH, 17'h0FFFF);
        send_item(MODE_SAMPLE, 17'h00001);
        for (int i = 0; i < 3; i++)
            send_item(MODE_FLUSH, 17'h00000);
        // Largest registers clamp to 1024; stay in row 0, no results.
        set_frame(11'h7FF, 11'h7FF);
        for (int i = 0; i < 4; i++)
            send_item(MODE_SAMPLE, pick_sample());
        // Flush mode inside the frame counts as zero.
        set_frame(11'd4, 11'd2);
        for (int i = 0; i < 16; i++)
            send_item((i == 5 || i == 6) ? MODE_FLUSH : MODE_SAMPLE, pick_sample());
    endtask

    // Mostly whole frames with random content; some mode noise and cut-off frames.
    task automatic test_random_frames(input int n_items, input int idle_pct,
                                      input int stall_pct);
        int sent;
        int w;
        int h;
        int total;
        logic mode;
        sender_idle_pct = idle_pct;
        rx_stall_pct    = stall_pct;
        sent = 0;
        while (sent < n_items)
        begin
            w = ($urandom_range(9) == 0) ? $urandom_range(2, 0) : $urandom_range(9, 3);
            h = ($urandom_range(9) == 0) ? 0 : $urandom_range(5, 1);
            set_frame(11'(w), 11'(h));
            if (w < 3) w = 3;
            if (h < 1) h = 1;
            total = w * (h + 2);
            if ($urandom_range(7) == 0)
                total = $urandom_range(total - 1, 1);
            for (int i = 0; i < total; i++)
            begin
                if (i < w * h)
                    mode = ($urandom_range(9) == 0) ? MODE_FLUSH : MODE_SAMPLE;
                else
                    mode = ($urandom_range(4) == 0) ? MODE_SAMPLE : MODE_FLUSH;
                send_item(mode, pick_sample());
            end
            sent += total;
        end
    endtask

    // Hold the output off long enough that the column item queue fills and input stalls.
    task automatic test_output_backpressure();
        sender_idle_pct = 0;
        rx_stall_pct    = 0;
        set_frame(11'd5, 11'd3);
        hold_token <= hold_token + 1;
        for (int i = 0; i < 25; i++)
            send_item(MODE_SAMPLE, pick_sample());
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_seen <= 0;
            hold_left <= 0;
        end
        else if (hold_seen != hold_token)
        begin
            hold_seen <= hold_token;
            hold_left <= 600;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        rms_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_rms.size() == 0)
            begin
                $error("unexpected result: rms %0d row %0d column %0d",
                       m_tdata[19:0], m_tdata[29:20], m_tdata[39:30]);
                error_count++;
            end
            else
            begin
                exp_r = pending_rms.pop_front();
                if (m_tdata[19:0] !== exp_r.rms)
                begin
                    $error("rms_value: expected %0d, got %0d", exp_r.rms, m_tdata[19:0]);
                    error_count++;
                end
                if (m_tdata[29:20] !== exp_r.row)
                begin
                    $error("out_row: expected %0d, got %0d", exp_r.row, m_tdata[29:20]);
                    error_count++;
                end
                if (m_tdata[39:30] !== exp_r.col)
                begin
                    $error("out_column: expected %0d, got %0d", exp_r.col, m_tdata[39:30]);
                    error_count++;
                end
                if (m_tlast !== exp_r.run_end)
                begin
                    $error("last_of_run: expected %0d, got %0d", exp_r.run_end, m_tlast);
                    error_count++;
                end
                if (m_tuser !== exp_r.frame_end)
                begin
                    $error("last_of_frame: expected %0d, got %0d", exp_r.frame_end, m_tuser);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n           <= 1'b0;
        s_tvalid        <= 1'b0;
        s_tdata         <= '0;
        s_tuser         <= 1'b0;
        cfg_valid       <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        sender_idle_pct = 0;
        rx_stall_pct    = 0;
        hold_token      = 0;
        width_reg       = 11'd1024;
        height_reg      = 11'd1024;
        for (int r = 0; r < lrw_pkg::LINES; r++)
            for (int c = 0; c < lrw_pkg::MAX_WIDTH; c++)
                line_mem[r][c] = '0;
        restart_frame();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_random_frames(PHASE_ITEMS, 0, 0);
        test_random_frames(PHASE_ITEMS, 62, 0);
        test_random_frames(PHASE_ITEMS, 0, 62);
        test_random_frames(PHASE_ITEMS, 20, 20);
        test_output_backpressure();
        wait_idle();

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
